// ===== sv/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg: shared types, constants and helpers for the order book matcher
// Book sizing, field widths, the controller/datapath command and status
// structs, and the mod 1000000007 helpers used by the backlog tracker.
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int BOOK_DEPTH = 256;
   localparam int IDX_W      = $clog2(BOOK_DEPTH);
   localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
   localparam int ADDR_W     = IDX_W + 1;          // book select bit on top
   localparam int RAM_DEPTH  = 2 * (1 << IDX_W);

   localparam int PRICE_W    = 30;
   localparam int AMT_W      = 30;
   localparam int MOD_W      = 30;
   localparam int ENTRY_W    = PRICE_W + AMT_W;    // {amount, price}

   localparam int REQ_DATA_W = 64;                 // price, amount, pad
   localparam int RSP_DATA_W = 96;                 // filled, rested, backlog, pad

   localparam logic [MOD_W-1:0] MOD_P      = 30'd1000000007;
   localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(BOOK_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(BOOK_DEPTH);

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic load;         // take a new order
      logic rd_head;      // read best entry of opposite book
      logic match_exec;   // consume from best opposite entry
      logic ins_start;    // insertion slot starts at tail of own book
      logic rd_ins;       // read own entry just above the slot
      logic shift;        // move that entry down one slot
      logic ins_write;    // place remainder into slot
      logic set_ovf;      // own book full, drop remainder
      logic mod_sub;      // backlog -= filled
      logic mod_add;      // backlog += rested
      logic out_load;     // capture result into output register
   } cmd_type;

   typedef struct packed {
      logic opp_empty;
      logic rem_zero;
      logic crosses;
      logic own_full;
      logic idx_zero;
      logic worse;
      logic out_free;
   } sts_type;

   // head + offset, wrapped at the book depth
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] s;
      s = {1'b0, head} + {1'b0, off};
      if (s >= DEPTH_WIDE) s = s - DEPTH_WIDE;
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [MOD_W-1:0] mod_reduce(input logic [MOD_W-1:0] x);
      return (x >= MOD_P) ? (x - MOD_P) : x;
   endfunction

   function automatic logic [MOD_W-1:0] mod_sub(input logic [MOD_W-1:0] m,
                                                input logic [MOD_W-1:0] x);
      logic [MOD_W-1:0] xr;
      xr = mod_reduce(x);
      return (m >= xr) ? (m - xr) : (m + (MOD_P - xr));
   endfunction

   function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] m,
                                                input logic [MOD_W-1:0] x);
      logic [MOD_W:0] s;
      s = {1'b0, m} + {1'b0, mod_reduce(x)};
      if (s >= {1'b0, MOD_P}) s = s - {1'b0, MOD_P};
      return s[MOD_W-1:0];
   endfunction

endpackage

// ===== sv/lobm_ram.sv =====
// ----------------------------------------------------------------------------
// lobm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lobm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lobm_ctrl: order sequencing state machine
// Walks one order through match, insert, backlog update and result hand-off.
// ----------------------------------------------------------------------------
module lobm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  lobm_pkg::sts_type sts,
   output lobm_pkg::cmd_type cmd
);
   import lobm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M_CHK, ST_M_EX, ST_I_CHK, ST_I_RD, ST_I_CMP, ST_I_WR,
      ST_B_SUB, ST_B_ADD, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_M_CHK;
            end
         end
         ST_M_CHK: begin
            if (sts.opp_empty || sts.rem_zero) begin
               state_in = ST_I_CHK;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_M_EX;
            end
         end
         ST_M_EX: begin
            if (sts.crosses) begin
               cmd.match_exec = 1'b1;
               state_in       = ST_M_CHK;
            end else begin
               state_in = ST_I_CHK;
            end
         end
         ST_I_CHK: begin
            priority if (sts.rem_zero) begin
               state_in = ST_B_SUB;
            end else if (sts.own_full) begin
               cmd.set_ovf = 1'b1;
               state_in    = ST_B_SUB;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = ST_I_RD;
            end
         end
         ST_I_RD: begin
            if (sts.idx_zero) begin
               state_in = ST_I_WR;
            end else begin
               cmd.rd_ins = 1'b1;
               state_in   = ST_I_CMP;
            end
         end
         ST_I_CMP: begin
            if (sts.worse) begin
               cmd.shift = 1'b1;
               state_in  = ST_I_RD;
            end else begin
               state_in = ST_I_WR;
            end
         end
         ST_I_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = ST_B_SUB;
         end
         ST_B_SUB: begin
            cmd.mod_sub = 1'b1;
            state_in    = ST_B_ADD;
         end
         ST_B_ADD: begin
            cmd.mod_add = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/lobm_dp.sv =====
// ----------------------------------------------------------------------------
// lobm_dp: order book datapath
// Both books share one RAM as circular buffers (book bit on the address MSB),
// plus order registers, backlog residue and the output register.
// ----------------------------------------------------------------------------
module lobm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  lobm_pkg::cmd_type                 cmd,
   output lobm_pkg::sts_type                 sts,
   input  logic [lobm_pkg::PRICE_W-1:0]      in_price,
   input  logic [lobm_pkg::AMT_W-1:0]        in_amount,
   input  logic                              in_side,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [lobm_pkg::AMT_W-1:0]        out_filled,
   output logic [lobm_pkg::AMT_W-1:0]        out_rested,
   output logic                              out_ovf,
   output logic [lobm_pkg::MOD_W-1:0]        out_backlog
);
   import lobm_pkg::*;

   logic [PRICE_W-1:0] price_ff;
   logic [AMT_W-1:0]   rem_ff, rem_in;
   logic               side_ff;
   logic [AMT_W-1:0]   filled_ff, filled_in;
   logic [AMT_W-1:0]   rested_ff, rested_in;
   logic               ovf_ff, ovf_in;
   logic [MOD_W-1:0]   bmod_ff, bmod_in;
   logic [IDX_W-1:0]   head_ff [2];
   logic [IDX_W-1:0]   head_in [2];
   logic [CNT_W-1:0]   count_ff [2];
   logic [CNT_W-1:0]   count_in [2];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AMT_W-1:0]   o_filled_ff, o_rested_ff;
   logic               o_ovf_ff;
   logic [MOD_W-1:0]   o_bmod_ff;

   logic               opp, own;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic               rd_en, wr_en;
   logic [PRICE_W-1:0] e_price;
   logic [AMT_W-1:0]   e_amount, take;
   logic               pop;

   assign opp      = ~side_ff;
   assign own      = side_ff;
   assign e_price  = rd_data[PRICE_W-1:0];
   assign e_amount = rd_data[ENTRY_W-1:PRICE_W];
   assign pop      = (e_amount <= rem_ff);
   assign take     = pop ? e_amount : rem_ff;

   lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // RAM ports
   always_comb begin
      rd_en   = cmd.rd_head | cmd.rd_ins;
      rd_addr = cmd.rd_head ? {opp, head_ff[opp]}
                            : {own, wrap_idx(head_ff[own], idx_ff - IDX_W'(1))};
      wr_en   = (cmd.match_exec & ~pop) | cmd.shift | cmd.ins_write;
      wr_addr = cmd.match_exec ? {opp, head_ff[opp]}
                               : {own, wrap_idx(head_ff[own], idx_ff)};
      priority if (cmd.match_exec) wr_data = {e_amount - take, e_price};
      else if (cmd.shift)          wr_data = rd_data;
      else                         wr_data = {rem_ff, price_ff};
   end

   // status to controller
   always_comb begin
      sts.opp_empty = (count_ff[opp] == '0);
      sts.rem_zero  = (rem_ff == '0);
      sts.crosses   = (side_ff == SIDE_BUY) ? (e_price <= price_ff) : (e_price >= price_ff);
      sts.own_full  = (count_ff[own] >= DEPTH_CNT);
      sts.idx_zero  = (idx_ff == '0);
      sts.worse     = (side_ff == SIDE_BUY) ? (e_price < price_ff) : (e_price > price_ff);
      sts.out_free  = ~rsp_valid_ff | rsp_tready;
   end

   always_comb begin
      rem_in       = rem_ff;
      filled_in    = filled_ff;
      rested_in    = rested_ff;
      ovf_in       = ovf_ff;
      bmod_in      = bmod_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.load) begin
         rem_in    = in_amount;
         filled_in = '0;
         rested_in = '0;
         ovf_in    = 1'b0;
      end
      if (cmd.match_exec) begin
         rem_in    = rem_ff - take;
         filled_in = filled_ff + take;
         if (pop) begin
            head_in[opp]  = wrap_idx(head_ff[opp], IDX_W'(1));
            count_in[opp] = count_ff[opp] - CNT_W'(1);
         end
      end
      if (cmd.ins_start) idx_in = count_ff[own][IDX_W-1:0];
      if (cmd.shift)     idx_in = idx_ff - IDX_W'(1);
      if (cmd.ins_write) begin
         count_in[own] = count_ff[own] + CNT_W'(1);
         rested_in     = rem_ff;
      end
      if (cmd.set_ovf) ovf_in  = 1'b1;
      if (cmd.mod_sub) bmod_in = mod_sub(bmod_ff, filled_ff);
      if (cmd.mod_add) bmod_in = mod_add(bmod_ff, rested_ff);
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         bmod_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         bmod_ff      <= bmod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         price_ff <= in_price;
         side_ff  <= in_side;
      end
      rem_ff    <= rem_in;
      filled_ff <= filled_in;
      rested_ff <= rested_in;
      ovf_ff    <= ovf_in;
      idx_ff    <= idx_in;
      if (cmd.out_load) begin
         o_filled_ff <= filled_ff;
         o_rested_ff <= rested_ff;
         o_ovf_ff    <= ovf_ff;
         o_bmod_ff   <= bmod_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign out_filled  = o_filled_ff;
   assign out_rested  = o_rested_ff;
   assign out_ovf     = o_ovf_ff;
   assign out_backlog = o_bmod_ff;

endmodule

// ===== sv/limit_order_book_matcher_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core: price/time priority limit order matcher
// Keeps a buy and a sell book and reports fill, rest and backlog per order.
// ----------------------------------------------------------------------------
// One order is in work at a time; the result sits in an output register, so
// the next order is taken while the previous result still waits. An order
// trades against the best opposite entry while it crosses and quantity
// remains; a remainder then rests unless the own book is full, its slot walking
// up from the tail past worse-priced entries (each shifted back one slot) and
// stopping behind an entry of equal or better price. The backlog then takes off
// the fill and adds the rest. A result that still waits in the output register
// holds the order in its last state. The step sequence is set by the single
// shared book RAM: one read and one write per cycle, read data registered. Both
// books are circular buffers in that RAM, so taking the best entry off a book
// is a head pointer bump. The backlog is tracked directly as a residue mod
// 1000000007. Book contents need no clearing: only entries below each count
// are ever read.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [29:0] price, [59:30] amount, [63:60] zero
   input  logic [lobm_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_tuser: [0] side (0 buy, 1 sell)
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: [29:0] filled_amount, [59:30] rested_amount,
   //            [89:60] backlog_mod, [95:90] zero
   output logic [lobm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: [0] book_overflow
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);
   import lobm_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [AMT_W-1:0] filled, rested;
   logic [MOD_W-1:0] backlog;

   lobm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lobm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_price    (req_tdata[PRICE_W-1:0]),
      .in_amount   (req_tdata[PRICE_W+AMT_W-1:PRICE_W]),
      .in_side     (req_tuser),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .out_filled  (filled),
      .out_rested  (rested),
      .out_ovf     (rsp_tuser),
      .out_backlog (backlog)
   );

   assign rsp_tdata = {(RSP_DATA_W - 2 * AMT_W - MOD_W)'(0), backlog, rested, filled};

   // an accepted order blocks further transfers until its result is loaded
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("order accepted while another is in work");

   // consumption only when the best entry crosses and quantity remains
   a_match_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.match_exec |-> (sts.crosses && !sts.rem_zero && !sts.opp_empty))
      else $error("match on non-crossing or empty book");

   // never insert into a full book
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> !sts.own_full)
      else $error("insert into full book");

   // a loaded result is presented on the next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result loaded but not valid");

endmodule

// ===== bench/limit_order_book_matcher_core_tb.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core_tb: self-checking bench for the order matcher
// Drives buy and sell orders, predicts fill, rest, overflow and backlog from
// a bench-side copy of both books, and checks every response in order.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lobm_pkg::*;

   typedef struct {
      logic [AMT_W-1:0] filled;
      logic [AMT_W-1:0] rested;
      logic             ovf;
      logic [MOD_W-1:0] backlog;
   } fill_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // bench copy of both books, best entry at index 0
   logic [PRICE_W-1:0] bid_px[$], ask_px[$];
   logic [AMT_W-1:0]   bid_qty[$], ask_qty[$];
   logic [63:0]        resting_total = 0;

   fill_report_type pending_reports[$];
   int  mismatches = 0;
   bit  sink_quiet = 1'b0;   // long receiver hold-off
   bit  send_calm  = 1'b0;   // no sender gaps
   bit  sink_calm  = 1'b0;   // no receiver stalls

   always #4 clock = ~clock;

   limit_order_book_matcher_core u_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   // Price/time priority matching on the bench books.
   function automatic fill_report_type match_order(logic [PRICE_W-1:0] px,
                                                   logic [AMT_W-1:0] qty,
                                                   logic side);
      fill_report_type r;
      logic [AMT_W-1:0] left, take;
      int pos;
      r.filled = '0;
      r.rested = '0;
      r.ovf = 1'b0;
      left = qty;
      if (side == SIDE_BUY) begin
         while (ask_px.size() > 0 && left != 0 && ask_px[0] <= px) begin
            take = (left < ask_qty[0]) ? left : ask_qty[0];
            ask_qty[0] -= take;
            left -= take;
            r.filled += take;
            if (ask_qty[0] == 0) begin
               void'(ask_px.pop_front());
               void'(ask_qty.pop_front());
            end
         end
      end else begin
         while (bid_px.size() > 0 && left != 0 && bid_px[0] >= px) begin
            take = (left < bid_qty[0]) ? left : bid_qty[0];
            bid_qty[0] -= take;
            left -= take;
            r.filled += take;
            if (bid_qty[0] == 0) begin
               void'(bid_px.pop_front());
               void'(bid_qty.pop_front());
            end
         end
      end
      resting_total -= r.filled;
      if (left != 0) begin
         if (side == SIDE_BUY) begin
            if (bid_px.size() >= BOOK_DEPTH) r.ovf = 1'b1;
            else begin
               // new entry goes behind every entry of equal or better price
               pos = 0;
               while (pos < bid_px.size() && !(bid_px[pos] < px)) pos++;
               bid_px.insert(pos, px);
               bid_qty.insert(pos, left);
            end
         end else begin
            if (ask_px.size() >= BOOK_DEPTH) r.ovf = 1'b1;
            else begin
               pos = 0;
               while (pos < ask_px.size() && !(ask_px[pos] > px)) pos++;
               ask_px.insert(pos, px);
               ask_qty.insert(pos, left);
            end
         end
         if (!r.ovf) begin
            r.rested = left;
            resting_total += left;
         end
      end
      r.backlog = MOD_W'(resting_total % 64'd1000000007);
      return r;
   endfunction

   // Appends one expected result to the tail of the queue.
   task automatic queue_report(fill_report_type r);
      pending_reports = {pending_reports, r};
   endtask

   // One transfer on the request side; prediction made at acceptance.
   // tvalid is left high after the transfer; the next call replaces the data or
   // drops tvalid for a gap, and wait_drained drops it, in the same time step.
   task automatic send_order(logic [PRICE_W-1:0] px, logic [AMT_W-1:0] qty,
                             logic side);
      while (!send_calm && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {4'b0, qty, px};
      req_tuser <= side;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queue_report(match_order(px, qty, side));
   endtask

   // Back-to-back variant keeps tvalid high between transfers.
   task automatic send_burst(int n, logic side_fixed, bit use_fixed);
      for (int i = 0; i < n; i++) begin
         req_tdata <= {4'b0, 30'($urandom_range(1000, 1)), 30'($urandom_range(5000, 4000))};
         req_tuser <= use_fixed ? side_fixed : logic'($urandom_range(1));
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         queue_report(match_order(req_tdata[29:0], req_tdata[59:30], req_tuser));
      end
   endtask

   // Receiver readiness, with random stalls and an optional long hold-off.
   always @(posedge clock) begin
      if (reset || sink_quiet) rsp_tready <= 1'b0;
      else rsp_tready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 9);
   end

   // Response checker.
   always @(posedge clock) begin
      fill_report_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response %h", $time, rsp_tdata);
         end else begin
            e = pending_reports.pop_front();
            if (rsp_tdata[29:0] !== e.filled) begin
               mismatches++;
               $display("%0t: filled exp %0d got %0d", $time, e.filled, rsp_tdata[29:0]);
            end
            if (rsp_tdata[59:30] !== e.rested) begin
               mismatches++;
               $display("%0t: rested exp %0d got %0d", $time, e.rested, rsp_tdata[59:30]);
            end
            if (rsp_tdata[89:60] !== e.backlog) begin
               mismatches++;
               $display("%0t: backlog exp %0d got %0d", $time, e.backlog,
                        rsp_tdata[89:60]);
            end
            if (rsp_tuser !== e.ovf) begin
               mismatches++;
               $display("%0t: overflow exp %0b got %0b", $time, e.ovf, rsp_tuser);
            end
         end
      end
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // Extremes of every field, both sides, equal-price time priority, zero amount.
   task automatic test_directed();
      send_order(30'd100, 30'd10, SIDE_BUY);
      send_order(30'd100, 30'd20, SIDE_BUY);          // same price, rests behind
      send_order(30'd100, 30'd15, SIDE_SELL);         // hits older bid first
      send_order(30'd0, 30'd0, SIDE_SELL);            // zero amount
      send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY); // above-range amount
      send_order(30'h3FFFFFFF, 30'd1000000000, SIDE_SELL);
      send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL);     // sweeps bid book
      send_order(30'd0, 30'd1, SIDE_BUY);
      send_order(30'h3FFFFFFF, 30'h2AAAAAAA, SIDE_BUY);
      send_order(30'h15555555, 30'h15555555, SIDE_SELL);
      send_order(30'd50, 30'd5, SIDE_SELL);           // no cross
      send_order(30'd49, 30'd5, SIDE_BUY);
      wait_drained();
   endtask

   // Fill the sell book past its depth so the remainder is dropped.
   task automatic test_overflow();
      sink_calm = 1'b1;
      send_calm = 1'b1;
      send_burst(BOOK_DEPTH + 4, SIDE_SELL, 1'b1);
      send_order(30'd3000, 30'd7, SIDE_SELL);
      send_calm = 1'b0;
      sink_calm = 1'b0;
      wait_drained();
   endtask

   // Receiver holds off while orders keep coming, so the input stalls.
   task automatic test_backpressure();
      sink_quiet = 1'b1;
      fork
         send_burst(20, SIDE_BUY, 1'b0);
         begin
            repeat (400) @(posedge clock);
            sink_quiet = 1'b0;
         end
      join
      wait_drained();
   endtask

   // Random crossing traffic, mostly around a mid price band near 5000.
   task automatic test_random();
      logic [PRICE_W-1:0] px;
      logic [AMT_W-1:0] qty;
      int r;
      for (int i = 0; i < 1000; i++) begin
         r = $urandom_range(99);
         if (r < 80) px = 30'($urandom_range(5060, 4940));
         else px = 30'($urandom);
         if (r < 70) qty = 30'($urandom_range(1000, 1));
         else if (r < 95) qty = 30'($urandom);
         else qty = 30'($urandom_range(1));
         send_calm = (i >= 400 && i < 500);
         sink_calm = send_calm;
         // keep books shallow enough most of the time
         send_order(px, qty, logic'($urandom_range(1)));
      end
      send_calm = 1'b0;
      sink_calm = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random();
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("limit_order_book_matcher_core_tb OK");
      else $display("limit_order_book_matcher_core_tb NOT OK");
      $finish;
   end

   initial begin
      #100ms;
      $display("limit_order_book_matcher_core_tb NOT OK");
      $finish;
   end
endmodule

// ===== files.f =====
sv/lobm_pkg.sv
sv/lobm_ram.sv
sv/lobm_ctrl.sv
sv/lobm_dp.sv
sv/limit_order_book_matcher_core.sv
bench/limit_order_book_matcher_core_tb.sv
